>>> src/i2cms_pkg.sv
// Shared types and constants of the I2C master write/read-back sequencer.
// No dependencies; every other file of the block imports this package.
package i2cms_pkg;

	localparam logic [1:0] CMD_EVENT = 2'd0;
	localparam logic [1:0] CMD_BEGIN_WRITE = 2'd1;
	localparam logic [1:0] CMD_BEGIN_READ = 2'd2;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_ADDRESS = 3'd1;
	localparam logic [2:0] PH_DATA = 3'd2;
	localparam logic [2:0] PH_REP_START = 3'd3;
	localparam logic [2:0] PH_RD_ADDRESS = 3'd4;
	localparam logic [2:0] PH_READ = 3'd5;
	localparam logic [2:0] PH_STOP = 3'd6;

	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_TRIG = 3'd1;
	localparam logic [2:0] ACT_START = 3'd2;
	localparam logic [2:0] ACT_STOP = 3'd3;
	localparam logic [2:0] ACT_STA_ONLY = 3'd4;

	localparam logic [2:0] CLR_NONE = 3'd0;
	localparam logic [2:0] CLR_TIMEOUT = 3'd1;
	localparam logic [2:0] CLR_START = 3'd2;
	localparam logic [2:0] CLR_ACK = 3'd3;
	localparam logic [2:0] CLR_NACK = 3'd4;

	localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_TX_BYTE_0 = 2'd1;
	localparam logic [1:0] REG_TX_BYTE_1 = 2'd2;
	localparam logic [1:0] REG_TX_BYTE_2 = 2'd3;

	localparam logic [1:0] WRITE_LENGTH = 2'd3;
	localparam logic [1:0] READ_PREFIX_LENGTH = 2'd2;
	localparam logic [1:0] LAST_INDEX = 2'd3;
	localparam logic [7:0] FILL_BYTE = 8'hFF;

	typedef struct packed {
		logic [1:0] command;
		logic       timeout_flag;
		logic       start_flag;
		logic       ack_flag;
		logic       nack_flag;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] clear_flag;
		logic       write_data_valid;
		logic [7:0] write_data;
		logic [2:0] bus_action;
		logic       done_res;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       unhandled;
	} result_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [1:0] byte_index;
		logic       read_mode;
		logic       done_flag;
	} seq_state_t;

	typedef struct packed {
		logic [6:0] device_address;
		logic [7:0] tx_byte_0;
		logic [7:0] tx_byte_1;
		logic [7:0] tx_byte_2;
	} seq_cfg_t;

endpackage

>>> src/i2cms_if.sv
// Valid/ready channel interfaces for the sequencer's input and result words.
// Depends on i2cms_pkg for the payload types.
interface i2cms_item_if;
	import i2cms_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cms_result_if;
	import i2cms_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/i2cms_step.sv
// Next-state and response logic for one input word of the sequencer.
// Purely combinational; depends on i2cms_pkg.
module i2cms_step (
	input  i2cms_pkg::item_t      item,
	input  i2cms_pkg::seq_state_t cur,
	input  i2cms_pkg::seq_cfg_t   cfg,
	output i2cms_pkg::seq_state_t nxt,
	output i2cms_pkg::result_t    res
);
	import i2cms_pkg::*;

	logic [7:0] sla;
	logic [7:0] data_byte;
	logic [1:0] index_inc;
	logic [1:0] len;

	assign sla = {cfg.device_address, 1'b0};
	assign len = cur.read_mode ? READ_PREFIX_LENGTH : WRITE_LENGTH;

	always_comb begin
		case (cur.byte_index)
			2'd0: data_byte = cfg.tx_byte_0;
			2'd1: data_byte = cfg.tx_byte_1;
			2'd2: data_byte = cfg.tx_byte_2;
			default: data_byte = FILL_BYTE;
		endcase
		index_inc = (cur.byte_index == LAST_INDEX) ? cur.byte_index : cur.byte_index + 2'd1;
	end

	always_comb begin
		nxt = cur;
		res = '0;
		if (item.command == CMD_BEGIN_WRITE || item.command == CMD_BEGIN_READ) begin
			nxt.read_mode = (item.command == CMD_BEGIN_READ);
			nxt.byte_index = 2'd0;
			nxt.done_flag = 1'b0;
			nxt.phase = PH_START;
			res.bus_action = ACT_STA_ONLY;
		end else if (item.command == CMD_EVENT) begin
			if (item.timeout_flag) begin
				res.clear_flag = CLR_TIMEOUT;
			end else if (item.start_flag) begin
				res.clear_flag = CLR_START;
				res.bus_action = ACT_TRIG;
				if (!cur.read_mode || cur.phase == PH_START) begin
					res.write_data_valid = 1'b1;
					res.write_data = sla;
					nxt.phase = PH_ADDRESS;
				end else if (cur.phase == PH_REP_START) begin
					res.write_data_valid = 1'b1;
					res.write_data = sla | 8'h01;
					nxt.phase = PH_RD_ADDRESS;
				end
			end else if (item.ack_flag) begin
				res.clear_flag = CLR_ACK;
				case (cur.phase)
					PH_ADDRESS: begin
						res.write_data_valid = 1'b1;
						res.write_data = data_byte;
						nxt.byte_index = index_inc;
						nxt.phase = PH_DATA;
						res.bus_action = ACT_TRIG;
					end
					PH_DATA: begin
						if (cur.byte_index != len) begin
							res.write_data_valid = 1'b1;
							res.write_data = data_byte;
							nxt.byte_index = index_inc;
							res.bus_action = ACT_TRIG;
						end else if (cur.read_mode) begin
							nxt.phase = PH_REP_START;
							res.bus_action = ACT_START;
						end else begin
							nxt.done_flag = 1'b1;
							nxt.phase = PH_STOP;
							res.bus_action = ACT_STOP;
						end
					end
					PH_RD_ADDRESS: begin
						if (cur.read_mode) begin
							nxt.phase = PH_READ;
							res.bus_action = ACT_TRIG;
						end
					end
					default: begin
					end
				endcase
			end else if (item.nack_flag) begin
				res.clear_flag = CLR_NACK;
				if (!cur.read_mode) begin
					nxt.done_flag = 1'b0;
				end
				if (cur.phase == PH_ADDRESS) begin
					nxt.phase = PH_START;
					res.bus_action = ACT_START;
				end else if (!cur.read_mode && cur.phase == PH_DATA) begin
					nxt.phase = PH_STOP;
					res.bus_action = ACT_STOP;
				end else if (cur.read_mode && cur.phase == PH_READ) begin
					res.read_valid = 1'b1;
					res.read_byte = item.rx_byte;
					nxt.done_flag = 1'b1;
					nxt.phase = PH_STOP;
					res.bus_action = ACT_STOP;
				end else begin
					res.unhandled = 1'b1;
				end
			end
		end
		res.done_res = nxt.done_flag;
	end

endmodule

>>> src/i2c_master_write_read_sequencer.sv
// I2C master write/read-back sequencer, top level.
// Depends on i2cms_pkg, i2cms_if.sv and i2cms_step.
//
// Each input word is either a begin command or a bus status event, and
// each one yields exactly one result word describing the flag to clear,
// the byte to load and the bus action to issue. The block takes one word
// per clock cycle when the result side keeps up; a word is registered on
// entry, resolved against the sequencer state, and its result is loaded
// into the output register at the clock edge on which the output stage
// advances, which a stalled result side can hold off. The sequencer state
// is updated once per word at that same edge. The configuration registers
// should be written only while no word is in flight.
module i2c_master_write_read_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_wdata,
	i2cms_item_if.sink           item,
	i2cms_result_if.source       result
);
	import i2cms_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic       out_valid_q;
	result_t    out_data_q;
	logic       advance;
	seq_state_t state_q;
	seq_state_t state_next;
	seq_cfg_t   cfg_q;
	result_t    step_res;

	assign advance = !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign result.valid = out_valid_q;
	assign result.data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_wdata[6:0];
				REG_TX_BYTE_0: cfg_q.tx_byte_0 <= cfg_wdata;
				REG_TX_BYTE_1: cfg_q.tx_byte_1 <= cfg_wdata;
				REG_TX_BYTE_2: cfg_q.tx_byte_2 <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
	end

	i2cms_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg_q),
		.nxt  (state_next),
		.res  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_START, byte_index: 2'd0, read_mode: 1'b0, done_flag: 1'b0};
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= step_res;
		end
	end

	a_begin_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && (item_s1.command == CMD_BEGIN_WRITE
			|| item_s1.command == CMD_BEGIN_READ)) |=> !state_q.done_flag)
		else $error("begin command left the done flag set");

	a_read_ends_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.read_valid) |->
			(out_data_q.done_res && out_data_q.bus_action == ACT_STOP))
		else $error("read byte delivered without finishing the transfer");

	a_unhandled_is_nack: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.unhandled) |-> (out_data_q.clear_flag == CLR_NACK))
		else $error("unhandled flag raised for a non-nack event");

	a_done_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1) |=> (out_data_q.done_res == state_q.done_flag))
		else $error("reported done flag differs from sequencer state");

endmodule

>>> verif/i2c_master_write_read_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master write/read-back sequencer.
// Uses i2cms_pkg and the channel interfaces of i2cms_if.sv; it predicts each result word
// from its own copy of the sequencer state and checks it against the block output.
module i2c_master_write_read_sequencer_tb;
	import i2cms_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_WORDS = 340;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_wdata;

	i2cms_item_if item_if();
	i2cms_result_if res_if();

	i2c_master_write_read_sequencer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item(item_if),
		.result(res_if)
	);

	item_t pending_words[$];
	result_t expected_results[$];
	seq_cfg_t cfg_model;
	seq_state_t seq_model;
	result_t want;
	logic word_taken = 1'b0;
	logic steady = 1'b0;
	int fail_count = 0;
	int words_taken = 0;
	int results_seen = 0;
	int bytes_read_back = 0;
	int settings_used = 0;
	int counted_words = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] take_data_byte();
		logic [7:0] b;
		case (seq_model.byte_index)
			2'd0: b = cfg_model.tx_byte_0;
			2'd1: b = cfg_model.tx_byte_1;
			2'd2: b = cfg_model.tx_byte_2;
			default: b = FILL_BYTE;
		endcase
		if (seq_model.byte_index != LAST_INDEX)
			seq_model.byte_index = seq_model.byte_index + 2'd1;
		return b;
	endfunction

	function automatic result_t resolve_word(item_t w);
		result_t r;
		logic [7:0] sla;
		logic [1:0] len;
		r = '0;
		sla = {cfg_model.device_address, 1'b0};
		len = seq_model.read_mode ? READ_PREFIX_LENGTH : WRITE_LENGTH;
		case (w.command)
			CMD_BEGIN_WRITE, CMD_BEGIN_READ: begin
				seq_model.read_mode = (w.command == CMD_BEGIN_READ);
				seq_model.byte_index = '0;
				seq_model.done_flag = 1'b0;
				seq_model.phase = PH_START;
				r.bus_action = ACT_STA_ONLY;
			end
			CMD_EVENT: begin
				if (w.timeout_flag) begin
					r.clear_flag = CLR_TIMEOUT;
				end else if (w.start_flag) begin
					r.clear_flag = CLR_START;
					r.bus_action = ACT_TRIG;
					if (!seq_model.read_mode || seq_model.phase == PH_START) begin
						r.write_data_valid = 1'b1;
						r.write_data = sla;
						seq_model.phase = PH_ADDRESS;
					end else if (seq_model.phase == PH_REP_START) begin
						r.write_data_valid = 1'b1;
						r.write_data = sla | 8'h01;
						seq_model.phase = PH_RD_ADDRESS;
					end
				end else if (w.ack_flag) begin
					r.clear_flag = CLR_ACK;
					if (seq_model.phase == PH_ADDRESS) begin
						r.write_data_valid = 1'b1;
						r.write_data = take_data_byte();
						r.bus_action = ACT_TRIG;
						seq_model.phase = PH_DATA;
					end else if (seq_model.phase == PH_DATA) begin
						if (seq_model.byte_index != len) begin
							r.write_data_valid = 1'b1;
							r.write_data = take_data_byte();
							r.bus_action = ACT_TRIG;
						end else if (seq_model.read_mode) begin
							seq_model.phase = PH_REP_START;
							r.bus_action = ACT_START;
						end else begin
							seq_model.done_flag = 1'b1;
							seq_model.phase = PH_STOP;
							r.bus_action = ACT_STOP;
						end
					end else if (seq_model.read_mode && seq_model.phase == PH_RD_ADDRESS) begin
						seq_model.phase = PH_READ;
						r.bus_action = ACT_TRIG;
					end
				end else if (w.nack_flag) begin
					r.clear_flag = CLR_NACK;
					if (!seq_model.read_mode)
						seq_model.done_flag = 1'b0;
					if (seq_model.phase == PH_ADDRESS) begin
						seq_model.phase = PH_START;
						r.bus_action = ACT_START;
					end else if (!seq_model.read_mode && seq_model.phase == PH_DATA) begin
						seq_model.phase = PH_STOP;
						r.bus_action = ACT_STOP;
					end else if (seq_model.read_mode && seq_model.phase == PH_READ) begin
						r.read_valid = 1'b1;
						r.read_byte = w.rx_byte;
						seq_model.done_flag = 1'b1;
						seq_model.phase = PH_STOP;
						r.bus_action = ACT_STOP;
					end else begin
						r.unhandled = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.done_res = seq_model.done_flag;
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result word arrived with none expected");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("clear_flag", want.clear_flag, res_if.data.clear_flag);
					check_field("write_data_valid", want.write_data_valid,
						res_if.data.write_data_valid);
					check_field("write_data", want.write_data, res_if.data.write_data);
					check_field("bus_action", want.bus_action, res_if.data.bus_action);
					check_field("done_res", want.done_res, res_if.data.done_res);
					check_field("read_valid", want.read_valid, res_if.data.read_valid);
					check_field("read_byte", want.read_byte, res_if.data.read_byte);
					check_field("unhandled", want.unhandled, res_if.data.unhandled);
					if (want.read_valid)
						bytes_read_back++;
				end
			end
			if (item_if.valid === 1'b1 && item_if.ready === 1'b1) begin
				expected_results.push_back(resolve_word(item_if.data));
				words_taken++;
			end
			word_taken <= (item_if.valid === 1'b1) && (item_if.ready === 1'b1);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			item_if.valid <= 1'b0;
			item_if.data <= '0;
		end else if (item_if.valid && !word_taken) begin
		end else if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 7)) begin
			item_if.valid <= 1'b1;
			item_if.data <= pending_words.pop_front();
		end else begin
			item_if.valid <= 1'b0;
		end
		res_if.ready <= arst_n && (steady || $urandom_range(0, 99) >= 7);
	end

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic rnd_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic add_word(logic [1:0] cmd, logic to, logic st, logic ak, logic nk,
		logic [7:0] rx);
		item_t w;
		w.command = cmd;
		w.timeout_flag = to;
		w.start_flag = st;
		w.ack_flag = ak;
		w.nack_flag = nk;
		w.rx_byte = rx;
		pending_words.push_back(w);
		if (cmd != CMD_UNUSED && (cmd != CMD_EVENT || to || st || ak || nk))
			counted_words++;
	endtask

	task automatic add_event(logic [2:0] which);
		logic hi_a;
		logic hi_b;
		hi_a = rnd_bit();
		hi_b = rnd_bit();
		if ($urandom_range(0, 99) < 4)
			add_word(CMD_EVENT, 1'b1, hi_a, hi_b, rnd_bit(), rnd_byte());
		if ($urandom_range(0, 99) < 2)
			add_word(CMD_EVENT, 1'b0, 1'b0, 1'b0, 1'b0, rnd_byte());
		case (which)
			CLR_START: add_word(CMD_EVENT, 1'b0, 1'b1, hi_a, hi_b, rnd_byte());
			CLR_ACK: add_word(CMD_EVENT, 1'b0, 1'b0, 1'b1, hi_b, rnd_byte());
			default: add_word(CMD_EVENT, 1'b0, 1'b0, 1'b0, 1'b1, rnd_byte());
		endcase
	endtask

	task automatic add_begin(logic [1:0] cmd);
		add_word(cmd, rnd_bit(), rnd_bit(), rnd_bit(), rnd_bit(), rnd_byte());
	endtask

	task automatic add_write_txn();
		add_begin(CMD_BEGIN_WRITE);
		add_event(CLR_START);
		if ($urandom_range(0, 99) < 10) begin
			add_event(CLR_NACK);
			add_event(CLR_START);
		end
		for (int i = 0; i < WRITE_LENGTH; i++) begin
			if ($urandom_range(0, 99) < 4) begin
				add_event(CLR_NACK);
				return;
			end
			add_event(CLR_ACK);
		end
		add_event(CLR_ACK);
		if ($urandom_range(0, 99) < 8) begin
			add_event(CLR_START);
			add_event(CLR_ACK);
		end
	endtask

	task automatic add_read_txn();
		add_begin(CMD_BEGIN_READ);
		add_event(CLR_START);
		if ($urandom_range(0, 99) < 10) begin
			add_event(CLR_NACK);
			add_event(CLR_START);
		end
		for (int i = 0; i <= READ_PREFIX_LENGTH; i++) begin
			if ($urandom_range(0, 99) < 3) begin
				add_event(CLR_NACK);
				return;
			end
			add_event(CLR_ACK);
		end
		add_event(CLR_START);
		if ($urandom_range(0, 99) < 4)
			add_event(CLR_NACK);
		add_event(CLR_ACK);
		add_event(CLR_NACK);
		if ($urandom_range(0, 99) < 5)
			add_event(CLR_ACK);
	endtask

	task automatic add_noise();
		logic [1:0] cmd;
		repeat ($urandom_range(1, 4)) begin
			cmd = ($urandom_range(0, 19) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
			add_word(cmd, rnd_bit(), rnd_bit(), rnd_bit(), rnd_bit(), rnd_byte());
		end
	endtask

	task automatic drain_and_settle();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || item_if.valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_setting(logic [1:0] idx, logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_DEVICE_ADDRESS: cfg_model.device_address = value[6:0];
			REG_TX_BYTE_0: cfg_model.tx_byte_0 = value;
			REG_TX_BYTE_1: cfg_model.tx_byte_1 = value;
			default: cfg_model.tx_byte_2 = value;
		endcase
	endtask

	task automatic apply_settings(logic [7:0] addr, logic [7:0] b0, logic [7:0] b1,
		logic [7:0] b2);
		write_setting(REG_DEVICE_ADDRESS, addr);
		write_setting(REG_TX_BYTE_0, b0);
		write_setting(REG_TX_BYTE_1, b1);
		write_setting(REG_TX_BYTE_2, b2);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [7:0] pick_setting();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return 8'hFF;
			default: return rnd_byte();
		endcase
	endfunction

	initial begin
		int target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cfg_model = '0;
		seq_model.phase = PH_START;
		seq_model.byte_index = '0;
		seq_model.read_mode = 1'b0;
		seq_model.done_flag = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: events before any begin, a full write, then a stray start
		// and ack that send the fill byte, the data index being left past the three bytes.
		add_word(CMD_EVENT, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
		add_word(CMD_EVENT, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF);
		add_word(CMD_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
		add_word(CMD_BEGIN_WRITE, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00);
		add_word(CMD_EVENT, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00);
		add_word(CMD_EVENT, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
		repeat (4) add_word(CMD_EVENT, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
		add_word(CMD_EVENT, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
		add_word(CMD_EVENT, 1'b0, 1'b0, 1'b0, 1'b1, 8'hFF);
		add_word(CMD_EVENT, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
		add_word(CMD_EVENT, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
		drain_and_settle();

		// Extreme settings: read-back with an address nack restart and stray events.
		apply_settings(8'hFF, 8'hFF, 8'h00, 8'h80);
		add_word(CMD_BEGIN_READ, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF);
		add_word(CMD_EVENT, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
		add_word(CMD_EVENT, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
		add_word(CMD_EVENT, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
		repeat (3) add_word(CMD_EVENT, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
		add_word(CMD_EVENT, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
		add_word(CMD_EVENT, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
		add_word(CMD_EVENT, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
		add_word(CMD_EVENT, 1'b0, 1'b0, 1'b0, 1'b1, 8'hFF);
		add_word(CMD_EVENT, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
		add_word(CMD_EVENT, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
		drain_and_settle();

		for (int pass = 0; pass < 4; pass++) begin
			steady = (pass == 2);
			if (pass == 3)
				apply_settings(8'h00, 8'h00, 8'hFF, 8'hFF);
			else
				apply_settings(pick_setting(), pick_setting(), pick_setting(), pick_setting());
			target = counted_words + PHASE_WORDS;
			while (counted_words < target) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: add_write_txn();
					4, 5, 6, 7: add_read_txn();
					default: add_noise();
				endcase
			end
			drain_and_settle();
		end
		steady = 1'b0;
		repeat (8) @(posedge clk);

		$display("covered %0d words and %0d checked results over %0d register settings,",
			words_taken, results_seen, settings_used);
		$display("including %0d completed read-backs, with %0d mismatches",
			bytes_read_back, fail_count);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
src/i2cms_pkg.sv
src/i2cms_if.sv
src/i2cms_step.sv
src/i2c_master_write_read_sequencer.sv
verif/i2c_master_write_read_sequencer_tb.sv
